// ===== hw/rtl/obbs_pkg.sv =====
// ----------------------------------------------------------------------------
// obbs_pkg
// Shared types, constants and the coefficient table of the band splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package obbs_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned BandW   = 4;
  localparam int unsigned MagW    = 16;
  localparam int unsigned StateW  = 48;
  localparam int unsigned CoefW   = 32;
  localparam int unsigned RomDepth = 90;
  localparam int unsigned CoefIdxW = 7;
  localparam int unsigned CoefsPerStage = 5;
  localparam int unsigned AccW    = 56;
  localparam int unsigned DiffW   = 50;

  typedef enum logic [1:0] {
    BASE_D1   = 2'd0,
    BASE_D2   = 2'd1,
    BASE_ZERO = 2'd2,
    BASE_ACC  = 2'd3
  } base_e;

  typedef struct packed {
    logic                load_x;
    logic                rd_en;
    logic                mul_en;
    logic                mul_hi;
    logic                mul_y;
    logic                acc_en;
    base_e               base_sel;
    logic                neg;
    logic                latch_y;
    logic                latch_d1n;
    logic                wr_en;
    logic                next_stage;
    logic                restart_x;
    logic                band_en;
    logic                band_first;
    logic                top_en;
    logic [BandW-1:0]    band_idx;
    logic [CoefIdxW-1:0] coef_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  function automatic logic signed [CoefW-1:0] rom_coef(input logic [CoefIdxW-1:0] idx);
    logic signed [CoefW-1:0] c;
    logic [CoefIdxW-1:0]     k;
    // the table repeats each row twice: one row per biquad of a filter
    k = (idx >= CoefIdxW'(RomDepth)) ? CoefIdxW'(0) : idx;
    unique case (k) inside
      7'd0, 7'd2, 7'd5, 7'd7:     c = 32'sd5031;
      7'd1, 7'd6:                 c = 32'sd10063;
      7'd3, 7'd8:                 c = -32'sd1069083153;
      7'd4, 7'd9:                 c = 32'sd532232366;
      7'd10, 7'd12, 7'd15, 7'd17: c = 32'sd20039;
      7'd11, 7'd16:               c = 32'sd40078;
      7'd13, 7'd18:               c = -32'sd1064424654;
      7'd14, 7'd19:               c = 32'sd527633897;
      7'd20, 7'd22, 7'd25, 7'd27: c = 32'sd79469;
      7'd21, 7'd26:               c = 32'sd158937;
      7'd23, 7'd28:               c = -32'sd1055108845;
      7'd24, 7'd29:               c = 32'sd518555808;
      7'd30, 7'd32, 7'd35, 7'd37: c = 32'sd312500;
      7'd31, 7'd36:               c = 32'sd624999;
      7'd33, 7'd38:               c = -32'sd1036486433;
      7'd34, 7'd39:               c = 32'sd500865520;
      7'd40, 7'd42, 7'd45, 7'd47: c = 32'sd1208809;
      7'd41, 7'd46:               c = 32'sd2417618;
      7'd43, 7'd48:               c = -32'sd999310656;
      7'd44, 7'd49:               c = 32'sd467274981;
      7'd50, 7'd52, 7'd55, 7'd57: c = 32'sd4532636;
      7'd51, 7'd56:               c = 32'sd9065273;
      7'd53, 7'd58:               c = -32'sd925445286;
      7'd54, 7'd59:               c = 32'sd406704919;
      7'd60, 7'd62, 7'd65, 7'd67: c = 32'sd16081744;
      7'd61, 7'd66:               c = 32'sd32163488;
      7'd63, 7'd68:               c = -32'sd780741080;
      7'd64, 7'd69:               c = 32'sd308197144;
      7'd70, 7'd72, 7'd75, 7'd77: c = 32'sd52415283;
      7'd71, 7'd76:               c = 32'sd104830566;
      7'd73, 7'd78:               c = -32'sd506166750;
      7'd74, 7'd79:               c = 32'sd178956971;
      7'd80, 7'd82, 7'd85, 7'd87: c = 32'sd157245850;
      7'd81, 7'd86:               c = 32'sd314491699;
      7'd83, 7'd88:               c = 32'sd0;
      7'd84, 7'd89:               c = 32'sd92112486;
      default:                    c = 32'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [StateW-1:0] sat48(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'((64'sd1 <<< (StateW - 1)) - 64'sd1);
    lo = -hi - AccW'(1);
    if (v > hi) return StateW'(hi);
    if (v < lo) return StateW'(lo);
    return StateW'(v);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/obbs_datapath.sv =====
// ----------------------------------------------------------------------------
// obbs_datapath
// Shared multiplier, accumulator, delay row memory and band output register.
// ----------------------------------------------------------------------------
`default_nettype none

module obbs_datapath #(
  parameter int unsigned Rows = 18,
  parameter int unsigned RowW = (Rows > 1) ? $clog2(Rows) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire obbs_pkg::dp_cmd_t             cmd_i,
  input  wire logic [RowW-1:0]               row_i,
  output obbs_pkg::dp_status_t               status_o,
  input  wire logic [obbs_pkg::SampleW-1:0]  sample_i,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic [obbs_pkg::BandW-1:0]         band_o,
  output logic [obbs_pkg::MagW-1:0]          magnitude_o,
  output logic                               last_o
);
  import obbs_pkg::*;

  logic [2*StateW-1:0] mem [Rows];
  logic [Rows-1:0]     row_valid_q;
  logic [2*StateW-1:0] rd_q;
  logic                rd_valid_q;

  logic signed [StateW-1:0] x_q, cur_q, y_q, d1n_q;
  logic signed [StateW-1:0] d1, d2, opnd;
  logic signed [56:0]       m_q;
  logic signed [79:0]       plo_q, p;
  logic signed [50:0]       r;
  logic signed [AccW-1:0]   acc_q, base, sum;
  logic signed [CoefW-1:0]  coef;
  logic signed [24:0]       mul_b;
  logic signed [DiffW-1:0]  sub_q, diff, yabs;
  logic                     out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[row_i] <= {sat48(sum), d1n_q};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[row_i];
    end
  end

  // rows never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.wr_en) row_valid_q[row_i] <= 1'b1;
      if (cmd_i.rd_en) rd_valid_q <= row_valid_q[row_i];
    end
  end

  assign d1 = rd_valid_q ? signed'(rd_q[StateW-1:0]) : '0;
  assign d2 = rd_valid_q ? signed'(rd_q[2*StateW-1:StateW]) : '0;

  assign coef  = rom_coef(cmd_i.coef_idx);
  assign opnd  = cmd_i.mul_y ? y_q : cur_q;
  assign mul_b = cmd_i.mul_hi ? 25'(signed'(opnd[StateW-1:24]))
                              : signed'({1'b0, opnd[23:0]});

  // product rounded to q.16: floor((coef*x + 2^28) / 2^29)
  assign p = plo_q + (80'(m_q) <<< 24);
  assign r = p[79:29];

  always_comb begin
    case (cmd_i.base_sel)
      BASE_D1:   base = AccW'(d1);
      BASE_D2:   base = AccW'(d2);
      BASE_ZERO: base = '0;
      default:   base = acc_q;
    endcase
    sum = cmd_i.neg ? base - AccW'(r) : base + AccW'(r);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      m_q <= coef * mul_b;
      if (cmd_i.mul_hi) plo_q <= 80'(m_q) + 80'sd268435456;
    end
    if (cmd_i.acc_en) acc_q <= sum;
    if (cmd_i.latch_y) y_q <= sat48(sum);
    if (cmd_i.latch_d1n) d1n_q <= sat48(sum);
    if (cmd_i.load_x) begin
      x_q   <= StateW'(signed'(sample_i)) <<< 16;
      cur_q <= StateW'(signed'(sample_i)) <<< 16;
    end else if (cmd_i.restart_x) begin
      cur_q <= x_q;
    end else if (cmd_i.next_stage) begin
      cur_q <= y_q;
    end
  end

  assign yabs = y_q[StateW-1] ? -DiffW'(y_q) : DiffW'(y_q);

  always_comb begin
    if (cmd_i.top_en) diff = DiffW'(x_q) - sub_q;
    else if (cmd_i.band_first) diff = yabs;
    else diff = DiffW'(y_q) - sub_q;
  end

  function automatic logic [MagW-1:0] mag(input logic signed [DiffW-1:0] v);
    logic [DiffW:0] a;
    logic [DiffW:0] t;
    a = v[DiffW-1] ? (DiffW+1)'(-(DiffW+1)'(v)) : (DiffW+1)'(v);
    t = (a + (DiffW+1)'(32768)) >> 16;
    return (t > (DiffW+1)'(65535)) ? MagW'(65535) : t[MagW-1:0];
  endfunction

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.band_en || cmd_i.top_en) begin
      band_o      <= cmd_i.band_idx;
      magnitude_o <= mag(diff);
      last_o      <= cmd_i.top_en;
    end
    if (cmd_i.band_en) sub_q <= cmd_i.band_first ? yabs : DiffW'(y_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.band_en || cmd_i.top_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/obbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// obbs_ctrl
// Sequencer over filters, biquad stages and the five products of a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module obbs_ctrl #(
  parameter int unsigned LowpassFilters  = 9,
  parameter int unsigned StagesPerFilter = 2,
  parameter int unsigned Rows = LowpassFilters * StagesPerFilter,
  parameter int unsigned RowW = (Rows > 1) ? $clog2(Rows) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire obbs_pkg::dp_status_t status_i,
  output obbs_pkg::dp_cmd_t         cmd_o,
  output logic [RowW-1:0]           row_o
);
  import obbs_pkg::*;

  localparam int unsigned FiltW  = (LowpassFilters > 1) ? $clog2(LowpassFilters) : 1;
  localparam int unsigned StageW = (StagesPerFilter > 1) ? $clog2(StagesPerFilter) : 1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_RD    = 7'b0000010,
    ST_P_LO  = 7'b0000100,
    ST_P_HI  = 7'b0001000,
    ST_P_ACC = 7'b0010000,
    ST_BAND  = 7'b0100000,
    ST_TOP   = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [FiltW-1:0]    filt_q, filt_d;
  logic [StageW-1:0]   stage_q, stage_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [CoefIdxW-1:0] cptr_q, cptr_d;
  logic [2:0]          k_q, k_d;
  logic [2:0]          off;
  logic [CoefIdxW:0]   cidx;
  logic [CoefIdxW:0]   cnext;

  always_comb begin
    // products in order b0*x, b1*x, a1*y, b2*x, a2*y
    case (k_q)
      3'd0:    off = 3'd0;
      3'd1:    off = 3'd1;
      3'd2:    off = 3'd3;
      3'd3:    off = 3'd2;
      default: off = 3'd4;
    endcase
    cidx  = {1'b0, cptr_q} + (CoefIdxW+1)'(off);
    if (cidx >= (CoefIdxW+1)'(RomDepth)) cidx = cidx - (CoefIdxW+1)'(RomDepth);
    cnext = {1'b0, cptr_q} + (CoefIdxW+1)'(CoefsPerStage);
    if (cnext >= (CoefIdxW+1)'(RomDepth)) cnext = cnext - (CoefIdxW+1)'(RomDepth);
  end

  always_comb begin
    state_d = state_q;
    filt_d  = filt_q;
    stage_d = stage_q;
    row_d   = row_q;
    cptr_d  = cptr_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.base_sel = BASE_ZERO;
    cmd_o.coef_idx = cidx[CoefIdxW-1:0];
    cmd_o.mul_y    = (k_q == 3'd2) || (k_q == 3'd4);
    cmd_o.band_idx = BandW'(filt_q);
    in_stall_o     = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_x = 1'b1;
          filt_d  = '0;
          stage_d = '0;
          row_d   = '0;
          cptr_d  = '0;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.rd_en = 1'b1;
        k_d     = '0;
        state_d = ST_P_LO;
      end
      ST_P_LO: begin
        cmd_o.mul_en = 1'b1;
        state_d = ST_P_HI;
      end
      ST_P_HI: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_hi = 1'b1;
        state_d = ST_P_ACC;
      end
      ST_P_ACC: begin
        cmd_o.acc_en = 1'b1;
        k_d     = k_q + 3'd1;
        state_d = ST_P_LO;
        case (k_q)
          3'd0: begin
            cmd_o.base_sel = BASE_D1;
            cmd_o.latch_y  = 1'b1;
          end
          3'd1: cmd_o.base_sel = BASE_D2;
          3'd2: begin
            cmd_o.base_sel  = BASE_ACC;
            cmd_o.neg       = 1'b1;
            cmd_o.latch_d1n = 1'b1;
          end
          3'd3: cmd_o.base_sel = BASE_ZERO;
          default: begin
            cmd_o.base_sel   = BASE_ACC;
            cmd_o.neg        = 1'b1;
            cmd_o.wr_en      = 1'b1;
            cmd_o.next_stage = 1'b1;
            cptr_d = cnext[CoefIdxW-1:0];
            row_d  = (row_q == RowW'(Rows - 1)) ? '0 : row_q + RowW'(1);
            if (stage_q == StageW'(StagesPerFilter - 1)) begin
              stage_d = '0;
              state_d = ST_BAND;
            end else begin
              stage_d = stage_q + StageW'(1);
              state_d = ST_RD;
            end
          end
        endcase
      end
      ST_BAND: begin
        if (status_i.out_free) begin
          cmd_o.band_en    = 1'b1;
          cmd_o.band_first = (filt_q == '0);
          cmd_o.restart_x  = 1'b1;
          if (filt_q == FiltW'(LowpassFilters - 1)) begin
            state_d = ST_TOP;
          end else begin
            filt_d  = filt_q + FiltW'(1);
            state_d = ST_RD;
          end
        end
      end
      ST_TOP: begin
        cmd_o.band_idx = BandW'(LowpassFilters);
        if (status_i.out_free) begin
          cmd_o.top_en = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      filt_q  <= '0;
      stage_q <= '0;
      row_q   <= '0;
      cptr_q  <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      filt_q  <= filt_d;
      stage_q <= stage_d;
      row_q   <= row_d;
      cptr_q  <= cptr_d;
      k_q     <= k_d;
    end
  end

  assign row_o = row_q;

endmodule

`default_nettype wire

// ===== hw/rtl/octave_biquad_band_splitter.sv =====
// ----------------------------------------------------------------------------
// octave_biquad_band_splitter
// Lowpass biquad bank on one shared multiplier, emitting octave band levels.
// ----------------------------------------------------------------------------
// each biquad is a delay row read, then five products, each in three steps (low
//   half, high half, accumulate) through the one 32x25 multiplier
// one sample at a time, the next taken once the top band is queued
// reset clears the delay row valid bits, so all delay states read as zero
`default_nettype none

module octave_biquad_band_splitter #(
  parameter int unsigned LOWPASS_FILTERS   = 9,
  parameter int unsigned STAGES_PER_FILTER = 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [obbs_pkg::SampleW-1:0]  sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [obbs_pkg::BandW-1:0]         band_o,
  output logic [obbs_pkg::MagW-1:0]          magnitude_o,
  output logic                               last_o
);
  import obbs_pkg::*;

  localparam int unsigned Rows = LOWPASS_FILTERS * STAGES_PER_FILTER;
  localparam int unsigned RowW = (Rows > 1) ? $clog2(Rows) : 1;

  dp_cmd_t         cmd;
  dp_status_t      status;
  logic [RowW-1:0] row;

  obbs_ctrl #(
    .LowpassFilters  (LOWPASS_FILTERS),
    .StagesPerFilter (STAGES_PER_FILTER),
    .Rows            (Rows),
    .RowW            (RowW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .row_o      (row)
  );

  obbs_datapath #(
    .Rows (Rows),
    .RowW (RowW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .row_i       (row),
    .status_o    (status),
    .sample_i    (sample_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .band_o      (band_o),
    .magnitude_o (magnitude_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/obbs_checker.sv =====
// ----------------------------------------------------------------------------
// obbs_checker
// Port level checks of the band splitter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module obbs_checker #(
  parameter int unsigned LOWPASS_FILTERS = 9
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [15:0] sample_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [3:0]  band_o,
  input wire logic [15:0] magnitude_o,
  input wire logic        last_o
);

  localparam logic [3:0] TopBand = 4'(LOWPASS_FILTERS);

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(band_o) &&
      $stable(magnitude_o) && $stable(last_o))
    else $error("stalled output beat changed");

  // a stalled input beat is offered unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(sample_i))
    else $error("stalled input beat changed");

  // a new sample keeps the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a sample is in work");

  a_last_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> band_o == TopBand)
    else $error("last beat not on the top band");

  // the block only idles after the top band left its hands
  a_band0_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input open while bands are pending");

endmodule

bind octave_biquad_band_splitter obbs_checker #(
  .LOWPASS_FILTERS (LOWPASS_FILTERS)
) u_obbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .sample_i    (sample_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .band_o      (band_o),
  .magnitude_o (magnitude_o),
  .last_o      (last_o)
);

`default_nettype wire
